/* design/col_pkg.sv */
`default_nettype none

package col_pkg;

    // Fixed field widths of the request and response items
    localparam int CMD_W = 3;
    localparam int KEY_W = 64;
    localparam int CAT_W = 4;
    localparam int STS_W = 2;
    localparam int POS_W = 7;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LIST_ALL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LIST_ONE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;

    // Status codes
    localparam logic [STS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STS_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] item_key;
        logic [CAT_W-1:0] item_category;
    } req_item_t;

    typedef struct packed {
        logic [STS_W-1:0] status;
        logic [POS_W-1:0] position;
        logic [KEY_W-1:0] out_key;
        logic [CAT_W-1:0] out_category;
        logic             last;
    } rsp_item_t;

    // Outcome of the shared compare unit for one stored entry
    typedef struct packed {
        logic key_eq;
        logic cat_eq;
        logic cat_gt;
    } cmp_res_t;

    // Sequencer states
    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_INS_RD = 10'b00_0000_0010,
        S_INS_EV = 10'b00_0000_0100,
        S_REM_RD = 10'b00_0000_1000,
        S_REM_EV = 10'b00_0001_0000,
        S_SHF_RD = 10'b00_0010_0000,
        S_SHF_EV = 10'b00_0100_0000,
        S_LST_RD = 10'b00_1000_0000,
        S_LST_EV = 10'b01_0000_0000,
        S_FIN    = 10'b10_0000_0000
    } seq_state_t;

endpackage

`default_nettype wire

/* design/col_mem.sv */
`default_nettype none

module col_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 68
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* design/col_cmp.sv */
`default_nettype none

module col_cmp #(
    parameter int KEY_BITS = 64
) (
    input  wire logic [KEY_BITS-1:0]     ent_key,
    input  wire logic [col_pkg::CAT_W-1:0] ent_cat,
    input  wire logic [KEY_BITS-1:0]     item_key,
    input  wire logic [col_pkg::CAT_W-1:0] item_cat,
    output col_pkg::cmp_res_t            res
);

    import col_pkg::*;

    // Compare the stored entry against the request held in the sequencer
    always_comb
    begin
        res.key_eq = (ent_key == item_key);
        res.cat_eq = (ent_cat == item_cat);
        res.cat_gt = (ent_cat > item_cat);
    end

endmodule

`default_nettype wire

/* design/category_ordered_list_table.sv */
// category_ordered_list_table
//
// Keeps up to CAPACITY entries (key, category) ordered by category, equal
// categories in arrival order. Requests arrive on req_valid/req_ready with
// req_data; results leave on rsp_valid/rsp_ready with rsp_data, the last one
// of each request marked by rsp_data.last. Codes 5 to 7 are taken and dropped.
// One request is worked at a time: req_ready is high only while the sequencer
// is idle. Entries live in a single-port-write, registered-read memory, so the
// walk visits each entry in an address state and then a compare state. A
// response register decouples the sides: the next request is taken while the
// final result of the previous one still waits. A stalled receiver holds the
// list walk once a second match is found. Reset empties the table at once
// (count to zero); memory contents are not cleared.
`default_nettype none

module category_ordered_list_table #(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire col_pkg::req_item_t req_data,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output col_pkg::rsp_item_t      rsp_data
);

    import col_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int ENT_W = CAT_W + KEY_BITS;

    seq_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    ptr_reg, ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [CAT_W-1:0]    cat_reg, cat_next;
    rsp_item_t           pend_reg, pend_next;
    logic                pend_valid_reg, pend_valid_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_item_t           rsp_reg, rsp_next;

    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [ENT_W-1:0]    mem_wdata;
    logic [CNT_W-1:0]    raddr_full;
    logic [ENT_W-1:0]    rd_data;
    logic [KEY_BITS-1:0] rd_key;
    logic [CAT_W-1:0]    rd_cat;
    cmp_res_t            cmp;
    logic                slot_free;
    logic                push;
    rsp_item_t           push_data;
    logic                is_match;

    assign rd_key = rd_data[KEY_BITS-1:0];
    assign rd_cat = rd_data[KEY_BITS +: CAT_W];

    col_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (ENT_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (raddr_full[IDX_W-1:0]),
        .rdata (rd_data)
    );

    col_cmp #(
        .KEY_BITS (KEY_BITS)
    ) u_cmp (
        .ent_key  (rd_key),
        .ent_cat  (rd_cat),
        .item_key (key_reg),
        .item_cat (cat_reg),
        .res      (cmp)
    );

    // Pick the read address for the walk direction
    always_comb
    begin
        if (state_reg == S_INS_RD || state_reg == S_INS_EV)
        begin
            raddr_full = ptr_reg - CNT_W'(1);
        end
        else if (state_reg == S_SHF_RD || state_reg == S_SHF_EV)
        begin
            raddr_full = ptr_reg + CNT_W'(1);
        end
        else
        begin
            raddr_full = ptr_reg;
        end
    end

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign is_match  = (cmd_reg == CMD_LIST_ALL) || cmp.cat_eq;
    assign req_ready = (state_reg == S_IDLE);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        count_next      = count_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        cat_next        = cat_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        mem_we          = 1'b0;
        mem_waddr       = ptr_reg[IDX_W-1:0];
        mem_wdata       = {cat_reg, key_reg};
        push            = 1'b0;
        push_data       = pend_reg;
        push_data.last  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next        = req_data.cmd;
                    key_next        = req_data.item_key[KEY_BITS-1:0];
                    cat_next        = req_data.item_category;
                    pend_next       = '0;
                    pend_valid_next = 1'b0;
                    ptr_next        = '0;
                    unique case (req_data.cmd) inside
                        CMD_INSERT:
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                pend_next.status = ST_FULL;
                                state_next       = S_FIN;
                            end
                            else
                            begin
                                ptr_next   = count_reg;
                                state_next = S_INS_RD;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                pend_next.status = ST_EMPTY;
                                state_next       = S_FIN;
                            end
                            else
                            begin
                                pend_next.status = ST_NOT_FOUND;
                                state_next       = S_REM_RD;
                            end
                        end
                        CMD_LIST_ALL, CMD_LIST_ONE:
                        begin
                            pend_next.status = ST_EMPTY;
                            state_next       = S_LST_RD;
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_FIN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Insert: walk down from the tail, moving greater categories up
            S_INS_RD:
            begin
                if (ptr_reg == '0)
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_INS_EV;
                end
            end

            S_INS_EV:
            begin
                mem_we = 1'b1;
                if (cmp.cat_gt)
                begin
                    mem_wdata  = rd_data;
                    ptr_next   = ptr_reg - CNT_W'(1);
                    state_next = S_INS_RD;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_FIN;
                end
            end

            // Remove: search for the first matching key
            S_REM_RD:
            begin
                state_next = (ptr_reg == count_reg) ? S_FIN : S_REM_EV;
            end

            S_REM_EV:
            begin
                if (cmp.key_eq)
                begin
                    pend_next.status       = ST_OK;
                    pend_next.out_key      = KEY_W'(rd_key);
                    pend_next.out_category = rd_cat;
                    state_next             = S_SHF_RD;
                end
                else
                begin
                    ptr_next   = ptr_reg + CNT_W'(1);
                    state_next = S_REM_RD;
                end
            end

            // Close the gap: move each later entry down by one
            S_SHF_RD:
            begin
                if ((ptr_reg + CNT_W'(1)) == count_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_SHF_EV;
                end
            end

            S_SHF_EV:
            begin
                mem_we     = 1'b1;
                mem_wdata  = rd_data;
                ptr_next   = ptr_reg + CNT_W'(1);
                state_next = S_SHF_RD;
            end

            // List: hold one match back so the final one can carry last
            S_LST_RD:
            begin
                state_next = (ptr_reg == count_reg) ? S_FIN : S_LST_EV;
            end

            S_LST_EV:
            begin
                if (cmd_reg == CMD_LIST_ONE && cmp.cat_gt)
                begin
                    state_next = S_FIN;
                end
                else if (is_match)
                begin
                    if (!pend_valid_reg || slot_free)
                    begin
                        push                   = pend_valid_reg;
                        pend_next.status       = ST_OK;
                        pend_next.position     = POS_W'(ptr_reg) + POS_W'(1);
                        pend_next.out_key      = KEY_W'(rd_key);
                        pend_next.out_category = rd_cat;
                        pend_valid_next        = 1'b1;
                        ptr_next               = ptr_reg + CNT_W'(1);
                        state_next             = S_LST_RD;
                    end
                end
                else
                begin
                    ptr_next   = ptr_reg + CNT_W'(1);
                    state_next = S_LST_RD;
                end
            end

            // Send the final result of the request
            S_FIN:
            begin
                if (slot_free)
                begin
                    push           = 1'b1;
                    push_data.last = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Response register
    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (push)
        begin
            rsp_next       = push_data;
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload and walk registers
    always_ff @(posedge clk)
    begin
        ptr_reg  <= ptr_next;
        cmd_reg  <= cmd_next;
        key_reg  <= key_next;
        cat_reg  <= cat_next;
        pend_reg <= pend_next;
        rsp_reg  <= rsp_next;
    end

endmodule

`default_nettype wire

/* design/col_chk.sv */
`default_nettype none

module col_chk (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               req_valid,
    input wire logic               req_ready,
    input wire col_pkg::req_item_t req_data,
    input wire logic               rsp_valid,
    input wire logic               rsp_ready,
    input wire col_pkg::rsp_item_t rsp_data
);

    import col_pkg::*;

    // Hold a stalled result
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("stalled result changed or dropped");

    // Drop ready after taking a request that has work to do
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_data.cmd <= CMD_CLEAR) |=> !req_ready)
        else $error("ready stayed high after a valid request");

    // Keep the block busy while a non-final result is pending
    a_busy_mid_list: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.last |-> !req_ready)
        else $error("new request taken before final result");

    // Error results are single and carry no position
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.status != ST_OK) |->
            rsp_data.last && (rsp_data.position == '0))
        else $error("malformed error result");

endmodule

bind category_ordered_list_table col_chk u_col_chk (.*);

`default_nettype wire

/* bench/testbench.sv */
module testbench;
    import col_pkg::*;

    localparam int DEPTH        = 64;
    localparam int RUN_ITEMS    = 470;
    localparam int LIMIT        = 1000000;
    localparam int TAIL         = 200;
    localparam int CHOKE_CYCLES = 300;
    localparam int POOL_MAX     = 40;

    typedef struct packed {
        req_item_t  req;
        logic [2:0] gap;
        logic       drain;
        logic       choke;
    } pending_req_t;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    req_item_t req_data;
    logic      rsp_valid;
    logic      rsp_ready;
    rsp_item_t rsp_data;

    category_ordered_list_table #(
        .CAPACITY (DEPTH),
        .KEY_BITS (KEY_W)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    // Shadow copy of the ordered table
    logic [KEY_W-1:0] tbl_keys [DEPTH];
    logic [CAT_W-1:0] tbl_cats [DEPTH];
    int               tbl_count = 0;

    rsp_item_t        expected_rsps [$];
    pending_req_t     pending [$];
    logic [KEY_W-1:0] key_pool [$];

    int          errors      = 0;
    int          n_items     = 0;
    int          rsp_count   = 0;
    int unsigned cycles      = 0;
    int          gap_max     = 4;
    int          gap_cnt     = 0;
    int          rsp_wait    = 0;
    int          rsp_seen    = 0;
    int          hold_left   = 0;
    bit          rsp_calm    = 0;
    bit          req_taken   = 0;
    bit          rsp_taken   = 0;
    bit          choke_req   = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic flag_mismatch(input string msg);
        errors++;
        if (errors <= 100)
            $display("mismatch: %s", msg);
    endtask

    task automatic push_rsp(input logic [STS_W-1:0] st, input int pos,
                            input logic [KEY_W-1:0] k, input logic [CAT_W-1:0] c,
                            input logic lst);
        rsp_item_t r;
        r.status       = st;
        r.position     = pos[POS_W-1:0];
        r.out_key      = k;
        r.out_category = c;
        r.last         = lst;
        expected_rsps.push_back(r);
    endtask

    // Apply one accepted request to the shadow table and queue its results
    task automatic apply_request(input req_item_t r);
        int               at;
        int               i;
        int               hits;
        logic [KEY_W-1:0] rk;
        logic [CAT_W-1:0] rc;
        rsp_item_t        tail_rsp;
        case (r.cmd)
            CMD_INSERT:
            begin
                if (tbl_count >= DEPTH)
                    push_rsp(ST_FULL, 0, '0, '0, 1'b1);
                else
                begin
                    // go behind every entry of equal or lower category
                    at = tbl_count;
                    for (i = 0; i < tbl_count; i++)
                        if (tbl_cats[i] > r.item_category)
                        begin
                            at = i;
                            break;
                        end
                    for (i = tbl_count; i > at; i--)
                    begin
                        tbl_keys[i] = tbl_keys[i-1];
                        tbl_cats[i] = tbl_cats[i-1];
                    end
                    tbl_keys[at] = r.item_key;
                    tbl_cats[at] = r.item_category;
                    tbl_count++;
                    push_rsp(ST_OK, 0, '0, '0, 1'b1);
                end
            end
            CMD_REMOVE:
            begin
                if (tbl_count == 0)
                    push_rsp(ST_EMPTY, 0, '0, '0, 1'b1);
                else
                begin
                    at = -1;
                    for (i = 0; i < tbl_count; i++)
                        if (tbl_keys[i] == r.item_key)
                        begin
                            at = i;
                            break;
                        end
                    if (at < 0)
                        push_rsp(ST_NOT_FOUND, 0, '0, '0, 1'b1);
                    else
                    begin
                        rk = tbl_keys[at];
                        rc = tbl_cats[at];
                        // close the gap
                        for (i = at; i + 1 < tbl_count; i++)
                        begin
                            tbl_keys[i] = tbl_keys[i+1];
                            tbl_cats[i] = tbl_cats[i+1];
                        end
                        tbl_count--;
                        push_rsp(ST_OK, 0, rk, rc, 1'b1);
                    end
                end
            end
            CMD_LIST_ALL:
            begin
                if (tbl_count == 0)
                    push_rsp(ST_EMPTY, 0, '0, '0, 1'b1);
                else
                    for (i = 0; i < tbl_count; i++)
                        push_rsp(ST_OK, i + 1, tbl_keys[i], tbl_cats[i], i == tbl_count - 1);
            end
            CMD_LIST_ONE:
            begin
                hits = 0;
                if (tbl_count != 0 && tbl_cats[0] <= r.item_category)
                    for (i = 0; i < tbl_count; i++)
                    begin
                        if (tbl_cats[i] > r.item_category)
                            break;
                        if (tbl_cats[i] == r.item_category)
                        begin
                            push_rsp(ST_OK, i + 1, tbl_keys[i], tbl_cats[i], 1'b0);
                            hits++;
                        end
                    end
                if (hits == 0)
                    push_rsp(ST_EMPTY, 0, '0, '0, 1'b1);
                else
                begin
                    // mark the final match
                    tail_rsp = expected_rsps.pop_back();
                    tail_rsp.last = 1'b1;
                    expected_rsps.push_back(tail_rsp);
                end
            end
            CMD_CLEAR:
            begin
                tbl_count = 0;
                push_rsp(ST_OK, 0, '0, '0, 1'b1);
            end
            default:
            begin
                // unused codes: dropped without a result
            end
        endcase
    endtask

    function automatic logic [KEY_W-1:0] rand_key();
        return {$urandom(), $urandom()};
    endfunction

    // Bias toward a narrow band so equal categories pile up
    function automatic logic [CAT_W-1:0] rand_cat();
        if ($urandom_range(0, 1) != 0)
            return CAT_W'($urandom_range(0, 15));
        return CAT_W'($urandom_range(6, 8));
    endfunction

    task automatic queue_req(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] k,
                             input logic [CAT_W-1:0] c, input logic drain = 1'b0,
                             input logic choke = 1'b0);
        pending_req_t p;
        p.req.cmd           = cmd;
        p.req.item_key      = k;
        p.req.item_category = c;
        p.gap               = 3'($urandom_range(0, gap_max));
        p.drain             = drain;
        p.choke             = choke;
        pending.push_back(p);
        if (cmd <= CMD_CLEAR)
            n_items++;
    endtask

    // Pick a fresh key or, now and then, reuse one to make duplicates
    task automatic insert_key(output logic [KEY_W-1:0] k);
        if (key_pool.size() != 0 && $urandom_range(0, 3) == 0)
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else
            k = rand_key();
        key_pool.push_back(k);
        if (key_pool.size() > POOL_MAX)
            void'(key_pool.pop_front());
    endtask

    task automatic take_pool_key(output logic [KEY_W-1:0] k);
        int idx;
        if (key_pool.size() == 0)
            k = rand_key();
        else
        begin
            idx = $urandom_range(0, key_pool.size() - 1);
            k = key_pool[idx];
            key_pool.delete(idx);
        end
    endtask

    // Clear, run the table past full, then list and pick it apart
    task automatic queue_fill(input logic choke);
        logic [KEY_W-1:0] k;
        key_pool.delete();
        queue_req(CMD_CLEAR, rand_key(), rand_cat());
        repeat (DEPTH + 2)
        begin
            insert_key(k);
            queue_req(CMD_INSERT, k, rand_cat());
        end
        queue_req(CMD_LIST_ALL, rand_key(), rand_cat(), 1'b0, choke);
        queue_req(CMD_REMOVE, rand_key(), rand_cat());
        repeat (4)
            queue_req(CMD_LIST_ONE, rand_key(), rand_cat());
        repeat (6)
        begin
            take_pool_key(k);
            queue_req(CMD_REMOVE, k, rand_cat());
        end
        insert_key(k);
        queue_req(CMD_INSERT, k, rand_cat());
    endtask

    // Sample both handshakes, predict and check
    always @(posedge clk)
    begin : watch
        rsp_item_t want;
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("[category_ordered_list_table] ERROR");
            $finish;
        end
        if (rst_n && req_valid && req_ready)
        begin
            apply_request(req_data);
            req_taken = 1;
        end
        if (rst_n && rsp_valid && rsp_ready)
        begin
            rsp_taken = 1;
            if (expected_rsps.size() == 0)
                flag_mismatch($sformatf("result %0d with none expected: %h", rsp_count,
                                        rsp_data));
            else
            begin
                want = expected_rsps.pop_front();
                if (rsp_data.status !== want.status)
                    flag_mismatch($sformatf("result %0d status %0d, want %0d",
                                            rsp_count, rsp_data.status, want.status));
                if (rsp_data.position !== want.position)
                    flag_mismatch($sformatf("result %0d position %0d, want %0d",
                                            rsp_count, rsp_data.position, want.position));
                if (rsp_data.out_key !== want.out_key)
                    flag_mismatch($sformatf("result %0d key %h, want %h",
                                            rsp_count, rsp_data.out_key, want.out_key));
                if (rsp_data.out_category !== want.out_category)
                    flag_mismatch($sformatf("result %0d category %0d, want %0d", rsp_count,
                                            rsp_data.out_category, want.out_category));
                if (rsp_data.last !== want.last)
                    flag_mismatch($sformatf("result %0d last %b, want %b",
                                            rsp_count, rsp_data.last, want.last));
            end
            rsp_count++;
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left--;
        else if (choke_req)
        begin
            choke_req = 0;
            hold_left = CHOKE_CYCLES;
        end
    end

    // Offer pending requests
    always @(negedge clk)
    begin : drive_req
        logic      nv;
        req_item_t nd;
        if (rst_n)
        begin
            nv = req_valid;
            nd = req_data;
            if (req_taken)
            begin
                nv = 1'b0;
                req_taken = 0;
            end
            if (!nv && pending.size() != 0)
            begin
                if (pending[0].drain && expected_rsps.size() != 0)
                    gap_cnt = 0;
                else if (gap_cnt < pending[0].gap)
                    gap_cnt++;
                else
                begin
                    nd = pending[0].req;
                    nv = 1'b1;
                    if (pending[0].choke)
                        choke_req = 1;
                    void'(pending.pop_front());
                    gap_cnt = 0;
                end
            end
            req_valid <= nv;
            req_data  <= nd;
        end
    end

    // Stall the result side
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_taken)
            begin
                rsp_taken = 0;
                rsp_seen++;
                if (rsp_seen % 40 == 0)
                    rsp_calm = ($urandom_range(0, 2) == 0);
                rsp_wait = rsp_calm ? 0 : $urandom_range(0, 4);
            end
            if (hold_left != 0)
                rsp_ready <= 1'b0;
            else if (rsp_wait != 0)
            begin
                rsp_ready <= 1'b0;
                if (rsp_valid)
                    rsp_wait--;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        int               pick;
        bit               fill_a;
        bit               fill_b;
        bit               paused;
        logic [KEY_W-1:0] k;
        clk       = 1'b0;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_data  = '0;
        rsp_ready = 1'b0;
        fill_a    = 0;
        fill_b    = 0;
        paused    = 0;

        // Directed: empty table, extremes, ties, duplicates, misses, unused codes
        queue_req(CMD_LIST_ALL, '0, '0);
        queue_req(CMD_LIST_ONE, '1, '1);
        queue_req(CMD_REMOVE, '1, '0);
        queue_req(CMD_INSERT, '1, 4'd15);
        queue_req(CMD_INSERT, '0, 4'd0);
        queue_req(CMD_INSERT, {32{2'b01}}, 4'd7);
        queue_req(CMD_INSERT, {32{2'b10}}, 4'd7);
        queue_req(CMD_INSERT, '0, 4'd15);
        queue_req(CMD_LIST_ALL, rand_key(), 4'd9);
        queue_req(CMD_LIST_ONE, rand_key(), 4'd7);
        queue_req(CMD_LIST_ONE, rand_key(), 4'd3);
        queue_req(CMD_LIST_ONE, rand_key(), 4'd15);
        queue_req(CMD_REMOVE, 64'h0123_4567_89ab_cdef, 4'd0);
        queue_req(CMD_REMOVE, '0, 4'd5);
        queue_req(CMD_LIST_ONE, rand_key(), 4'd0);
        queue_req(CMD_LIST_ALL, rand_key(), 4'd0);
        queue_req(3'd5, rand_key(), rand_cat());
        queue_req(3'd6, '1, '1);
        queue_req(3'd7, '0, '0);
        queue_req(CMD_CLEAR, '1, '1);
        queue_req(CMD_LIST_ALL, '0, '0);
        queue_req(CMD_REMOVE, rand_key(), 4'd3);

        // Random: mostly inserts and removes of live keys, with listing and noise
        while (n_items < RUN_ITEMS)
        begin
            if ($urandom_range(0, 39) == 0)
                gap_max = (gap_max != 0) ? 0 : 4;
            if (!fill_a && n_items >= 100)
            begin
                fill_a = 1;
                queue_fill(1'b1);
            end
            else if (!fill_b && n_items >= 330)
            begin
                fill_b = 1;
                queue_fill(1'b0);
            end
            else if (!paused && n_items >= 250)
            begin
                paused = 1;
                queue_req(CMD_LIST_ALL, rand_key(), rand_cat(), 1'b1);
            end
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                insert_key(k);
                queue_req(CMD_INSERT, k, rand_cat());
            end
            else if (pick < 65)
            begin
                if ($urandom_range(0, 4) != 0)
                    take_pool_key(k);
                else
                    k = rand_key();
                queue_req(CMD_REMOVE, k, rand_cat());
            end
            else if (pick < 73)
                queue_req(CMD_LIST_ALL, rand_key(), rand_cat());
            else if (pick < 88)
                queue_req(CMD_LIST_ONE, rand_key(), rand_cat());
            else if (pick < 92)
            begin
                key_pool.delete();
                queue_req(CMD_CLEAR, rand_key(), rand_cat());
            end
            else
                queue_req(CMD_W'($urandom_range(5, 7)), rand_key(), rand_cat());
        end

        // Reset, then let the driver run dry
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        while (pending.size() != 0 || req_valid)
            @(posedge clk);
        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);
        if (errors == 0)
            $display("[category_ordered_list_table] OK");
        else
            $display("[category_ordered_list_table] ERROR");
        $finish;
    end

endmodule
